// ----- sv/packed_pixel_palette_decoder_top_defines.svh -----
// Assertion macros for the packed pixel palette decoder.
// Used by the port checker; needs clk_i and rst_ni in the including scope.
`ifndef PACKED_PIXEL_PALETTE_DECODER_TOP_DEFINES_SVH
`define PACKED_PIXEL_PALETTE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication.
`define PPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ppd_pkg.sv -----
// Shared constants and unpack helpers for the packed pixel palette decoder.
// No dependencies.
`default_nettype none

package ppd_pkg;

  localparam int unsigned PaletteEntries = 16;
  localparam int unsigned SlotW          = 4;
  localparam int unsigned ColorW         = 32;
  localparam int unsigned XW             = 11;
  localparam int unsigned YW             = 10;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 11;

  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_BYTE    = 1'b1;

  localparam logic [1:0] MODE_TWO_PX   = 2'd0;
  localparam logic [1:0] MODE_FOUR_PX  = 2'd1;
  localparam logic [1:0] MODE_EIGHT_PX = 2'd2;
  localparam logic [1:0] MODE_NONE     = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_PIXEL_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ROW_LEN    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ROW_COUNT  = 2'd2;

  localparam logic [1:0]  PIXEL_MODE_RST = 2'd1;
  localparam logic [8:0]  ROW_LEN_RST    = 9'd80;
  localparam logic [10:0] ROW_COUNT_RST  = 11'd200;

  // Palette index of pixel k of a byte, leftmost pixel from the high bits.
  function automatic logic [SlotW-1:0] pix_index(input logic [7:0] b,
                                                 input logic [1:0] mode,
                                                 input logic [2:0] k);
    logic [SlotW-1:0] idx;
    idx = '0;
    case (mode)
      MODE_TWO_PX: begin
        if (k[0] == 1'b0) idx = {b[1], b[3], b[5], b[7]};
        else              idx = {b[0], b[2], b[4], b[6]};
      end
      MODE_FOUR_PX:  idx = {2'b00, b[3'd3 - {1'b0, k[1:0]}], b[3'd7 - {1'b0, k[1:0]}]};
      MODE_EIGHT_PX: idx = {3'b000, b[3'd7 - k]};
      default:       idx = '0;
    endcase
    return idx;
  endfunction

  // Position of the final pixel in a byte.
  function automatic logic [2:0] last_k(input logic [1:0] mode);
    logic [2:0] r;
    case (mode)
      MODE_TWO_PX:   r = 3'd1;
      MODE_FOUR_PX:  r = 3'd3;
      MODE_EIGHT_PX: r = 3'd7;
      default:       r = 3'd0;
    endcase
    return r;
  endfunction

  // log2 of pixels per byte.
  function automatic logic [1:0] ppb_shift(input logic [1:0] mode);
    logic [1:0] r;
    case (mode)
      MODE_TWO_PX:   r = 2'd1;
      MODE_FOUR_PX:  r = 2'd2;
      MODE_EIGHT_PX: r = 2'd3;
      default:       r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/ppd_ifs.sv -----
// Channel interfaces: input items, pixel results, register writes.
// Depends on ppd_pkg for field widths.
`default_nettype none

interface ppd_item_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic [ppd_pkg::SlotW-1:0]       palette_slot;
  logic [ppd_pkg::ColorW-1:0]      palette_color;
  logic [7:0]                      data_byte;

  modport source (output valid, opcode, palette_slot, palette_color, data_byte,
                  input ready);
  modport sink   (input valid, opcode, palette_slot, palette_color, data_byte,
                  output ready);
endinterface

interface ppd_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [ppd_pkg::ColorW-1:0]  pixel_rgba;
  logic [ppd_pkg::XW-1:0]      pixel_x;
  logic [ppd_pkg::YW-1:0]      pixel_y;
  logic                        last_of_byte;
  logic                        last_of_frame;

  modport source (output valid, pixel_rgba, pixel_x, pixel_y, last_of_byte,
                  last_of_frame, input ready);
  modport sink   (input valid, pixel_rgba, pixel_x, pixel_y, last_of_byte,
                  last_of_frame, output ready);
endinterface

interface ppd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ppd_pkg::CfgIdxW-1:0]   index;
  logic [ppd_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/packed_pixel_palette_decoder_top.sv -----
// Packed pixel decoder: unpacks screen bytes into palette colors with x/y.
// Depends on ppd_pkg and the channel interfaces in ppd_ifs.sv.
//
// Use:
//   item_i  : one beat per palette write (opcode 0) or screen byte (opcode 1).
//   pixel_o : one beat per pixel, 2, 4 or 8 per byte by pixel_mode.
//   cfg_i   : register writes (0 pixel_mode, 1 row length, 2 row_count),
//             always ready; write only while the block is idle.
// Path: a byte beat loads the unpack stage, then the pixel output register.
// Throughput: one pixel per cycle while pixel_o.ready is high, set by the single
//   pixel output register. The next item is taken in the cycle the current
//   byte's final pixel moves to the output register, so bytes run back to
//   back. Palette writes and ignored bytes do not occupy the unpack stage.
// Reset: palette cleared to zero, position at column 0 row 0, pixel_mode 1,
//   row length 80, row_count 200. No clearing pass.
// Stall: while pixel_o.ready is low the output holds; the unpack stage
//   holds its byte and item_i.ready stays low until it drains.
`default_nettype none

module packed_pixel_palette_decoder_top #(
  parameter int unsigned MAX_ROW_LEN = 256,
  parameter int unsigned MAX_ROWS    = 1024
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  ppd_item_if.sink      item_i,
  ppd_pixel_if.source   pixel_o,
  ppd_cfg_if.sink       cfg_i
);

  localparam int unsigned ColW = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
  localparam int unsigned RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [1:0]  pixel_mode_q;
  logic [8:0]  row_len_q;
  logic [10:0] row_count_q;

  logic [ppd_pkg::ColorW-1:0] palette_q [ppd_pkg::PaletteEntries];
  logic [ColW-1:0]            byte_column_q;
  logic [RowW-1:0]            row_index_q;

  logic            busy_q;
  logic [7:0]      byte_q;
  logic [2:0]      k_q;
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic            frame_end_q;

  logic                       out_valid_q;
  logic [ppd_pkg::ColorW-1:0] out_rgba_q;
  logic [ppd_pkg::XW-1:0]     out_x_q;
  logic [ppd_pkg::YW-1:0]     out_y_q;
  logic                       out_lob_q;
  logic                       out_lof_q;

  logic        item_beat, cfg_beat, byte_go, pal_wr;
  logic        advance, stage_last, in_ready;
  logic [31:0] rb_sat, rc_sat, x_full, y_full;
  logic        row_end, frame_end;
  logic [ppd_pkg::SlotW-1:0] pix_idx;

  // Geometry, saturated to the build limits.
  assign rb_sat = (32'(row_len_q) > 32'(MAX_ROW_LEN)) ? 32'(MAX_ROW_LEN)
                                                      : 32'(row_len_q);
  assign rc_sat = (32'(row_count_q) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS)
                                                     : 32'(row_count_q);
  assign row_end   = (32'(byte_column_q) + 32'd1) >= rb_sat;
  assign frame_end = row_end && ((32'(row_index_q) + 32'd1) >= rc_sat);

  assign advance    = busy_q && (!out_valid_q || pixel_o.ready);
  assign stage_last = (k_q == ppd_pkg::last_k(pixel_mode_q));
  assign in_ready   = !busy_q || (advance && stage_last);

  assign item_beat = item_i.valid && in_ready;
  assign pal_wr    = item_beat && (item_i.opcode == ppd_pkg::OP_PALETTE);
  assign byte_go   = item_beat && (item_i.opcode == ppd_pkg::OP_BYTE) &&
                     (pixel_mode_q != ppd_pkg::MODE_NONE) && (rb_sat != 32'd0) &&
                     (rc_sat != 32'd0);
  assign cfg_beat  = cfg_i.valid;

  assign pix_idx = ppd_pkg::pix_index(byte_q, pixel_mode_q, k_q);
  assign x_full  = (32'(col_q) << ppd_pkg::ppb_shift(pixel_mode_q)) + 32'(k_q);
  assign y_full  = 32'(row_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_mode_q <= ppd_pkg::PIXEL_MODE_RST;
      row_len_q    <= ppd_pkg::ROW_LEN_RST;
      row_count_q  <= ppd_pkg::ROW_COUNT_RST;
    end else if (cfg_beat) begin
      case (cfg_i.index)
        ppd_pkg::REG_PIXEL_MODE: pixel_mode_q <= cfg_i.data[1:0];
        ppd_pkg::REG_ROW_LEN:    row_len_q    <= cfg_i.data[8:0];
        ppd_pkg::REG_ROW_COUNT:  row_count_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ppd_pkg::PaletteEntries; i++) begin
        palette_q[i] <= '0;
      end
    end else if (pal_wr) begin
      palette_q[item_i.palette_slot] <= item_i.palette_color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_column_q <= '0;
      row_index_q   <= '0;
    end else if (byte_go) begin
      if (row_end) begin
        byte_column_q <= '0;
        row_index_q   <= frame_end ? '0 : RowW'(row_index_q + 1'b1);
      end else begin
        byte_column_q <= ColW'(byte_column_q + 1'b1);
      end
    end
  end

  // Unpack stage: holds one byte and walks its pixels.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else if (byte_go) begin
      busy_q <= 1'b1;
      k_q    <= '0;
    end else if (advance && stage_last) begin
      busy_q <= 1'b0;
    end else if (advance) begin
      k_q <= k_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_go) begin
      byte_q      <= item_i.data_byte;
      col_q       <= byte_column_q;
      row_q       <= row_index_q;
      frame_end_q <= frame_end;
    end
  end

  // Pixel output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (pixel_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rgba_q <= palette_q[pix_idx];
      out_x_q    <= x_full[ppd_pkg::XW-1:0];
      out_y_q    <= y_full[ppd_pkg::YW-1:0];
      out_lob_q  <= stage_last;
      out_lof_q  <= stage_last && frame_end_q;
    end
  end

  assign item_i.ready          = in_ready;
  assign cfg_i.ready           = 1'b1;
  assign pixel_o.valid         = out_valid_q;
  assign pixel_o.pixel_rgba    = out_rgba_q;
  assign pixel_o.pixel_x       = out_x_q;
  assign pixel_o.pixel_y       = out_y_q;
  assign pixel_o.last_of_byte  = out_lob_q;
  assign pixel_o.last_of_frame = out_lof_q;

endmodule

`default_nettype wire

// ----- sv/ppd_checker.sv -----
// Port checker for the packed pixel decoder, bound to the top level.
// Depends on packed_pixel_palette_decoder_top_defines.svh and ppd_pkg.
`default_nettype none
`include "packed_pixel_palette_decoder_top_defines.svh"

module ppd_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             out_valid,
  input wire                             out_ready,
  input wire [ppd_pkg::ColorW-1:0]       out_rgba,
  input wire [ppd_pkg::XW-1:0]           out_x,
  input wire [ppd_pkg::YW-1:0]           out_y,
  input wire                             out_lob,
  input wire                             out_lof
);

  `PPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rgba) && $stable(out_x) && $stable(out_y) && $stable(out_lob) && $stable(out_lof), "pixel beat changed while stalled")
  `PPD_ASSERT_NOW(a_frame_ends_byte, out_valid && out_lof, out_lob, "frame end not on a byte end")
  `PPD_ASSERT_NEXT(a_byte_continues, out_valid && out_ready && !out_lob, out_valid && $stable(out_y), "byte pixels not contiguous")
  `PPD_ASSERT_NEXT(a_x_steps, out_valid && out_ready && !out_lob, out_x == ppd_pkg::XW'($past(out_x) + 1'b1), "pixel x did not step by one")

endmodule

bind packed_pixel_palette_decoder_top ppd_checker u_ppd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (pixel_o.valid),
  .out_ready (pixel_o.ready),
  .out_rgba  (pixel_o.pixel_rgba),
  .out_x     (pixel_o.pixel_x),
  .out_y     (pixel_o.pixel_y),
  .out_lob   (pixel_o.last_of_byte),
  .out_lof   (pixel_o.last_of_frame)
);

`default_nettype wire
